// ===== src/fpadd_pkg.sv =====
// Package: constants and types for the binary32 add/subtract block.
`default_nettype none
package fpadd_pkg;
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_A_SUB = 2'd1;
    localparam logic [1:0] CMD_B_SUB = 2'd2;

    localparam logic [1:0] RM_NEAREST = 2'd0;
    localparam logic [1:0] RM_ZERO    = 2'd1;
    localparam logic [1:0] RM_PLUS    = 2'd2;
    localparam logic [1:0] RM_MINUS   = 2'd3;

    localparam logic [31:0] QNAN_OUT  = 32'h7fffffff;
    localparam logic [22:0] QUIET_BIT = 23'h400000;
    localparam logic [31:0] INF_PAT   = 32'h7f800000;
    localparam logic [31:0] MAX_FIN   = 32'h7f7fffff;
    localparam logic [31:0] MIN_NORM  = 32'h00800000;
    localparam logic [31:0] INF_MASK  = 32'hff800000;

    // stage 1 -> stage 2: aligned operands
    typedef struct packed {
        logic        done;      // result already final (special case)
        logic [31:0] res;
        logic [8:0]  flags;
        logic        sign_l;
        logic        sign_r;
        logic [26:0] lsig;
        logic [26:0] rsig;
        logic [7:0]  exp;
        logic [1:0]  rm;
    } s1_t;

    // stage 2 -> stage 3: normalized significand
    typedef struct packed {
        logic        done;
        logic [31:0] res;
        logic [8:0]  flags;
        logic        sign;
        logic [26:0] sig;
        logic signed [9:0] exp;
        logic [1:0]  rm;
    } s2_t;

    // right shift with sticky bit
    function automatic logic [26:0] jam27(input logic [26:0] v, input logic [7:0] n);
        logic [26:0] sh;
        logic [26:0] mask;
        begin
            if (n >= 8'd27) begin
                jam27 = {26'd0, |v};
            end else begin
                sh   = v >> n;
                mask = ~(27'h7ffffff << n);
                jam27 = sh | {26'd0, |(v & mask)};
            end
        end
    endfunction

    // leading zero count of a 27-bit value (bit 26 is msb)
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] c;
        logic       f;
        begin
            c = 5'd0;
            f = 1'b0;
            for (int i = 26; i >= 0; i--) begin
                if (!f && v[i]) begin
                    f = 1'b1;
                    c = 5'(26 - i);
                end
            end
            lzc27 = c;
        end
    endfunction
endpackage
`default_nettype wire

// ===== src/binary32_add_subtract_top.sv =====
// Top level: three-stage pipelined binary32 adder/subtractor with flags.
// The start beat runs through the valid bits v1, v2 and v3; done is driven from v3.
// Throughput: one operation per cycle; busy is held low, start is taken every cycle.
// Stages: unpack/align, add and normalize, round and pack.
// Reset clears the stage valid bits and sets the rounding mode register to nearest even.
// Results cannot be stalled; each shows for one cycle with done high.
`default_nettype none
module binary32_add_subtract_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] source_a,
    input  wire logic [31:0] source_b,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    output logic             done,
    output logic [31:0]      sum_value,
    output logic             a_is_nan,
    output logic             b_is_nan,
    output logic             a_is_denormal,
    output logic             b_is_denormal,
    output logic             invalid_flag,
    output logic             infinite_flag,
    output logic             overflow_flag,
    output logic             inexact_flag,
    output logic             underflow_flag
);
    import fpadd_pkg::*;

    logic [1:0]  rm_reg;
    logic        v1_reg, v2_reg, v3_reg;
    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;
    logic [31:0] res3_reg, res3_next;
    logic [8:0]  fl3_reg, fl3_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // rounding mode register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rm_reg <= RM_NEAREST;
        end else if (cfg_valid) begin
            rm_reg <= cfg_data;
        end
    end

    // stage 1: classify, specials, align
    always_comb begin
        logic [7:0]  ea, eb, le, re;
        logic [22:0] fa, fb;
        logic        nana, nanb, infa, infb, dena, denb;
        logic [31:0] l, r;
        logic [8:0]  st;
        logic        ls, rs;
        logic [26:0] ls0, rs0;
        ea = source_a[30:23];
        eb = source_b[30:23];
        fa = source_a[22:0];
        fb = source_b[22:0];
        nana = (ea == 8'hff) && (fa != 23'd0);
        nanb = (eb == 8'hff) && (fb != 23'd0);
        infa = (ea == 8'hff) && (fa == 23'd0);
        infb = (eb == 8'hff) && (fb == 23'd0);
        dena = (ea == 8'd0) && (fa != 23'd0);
        denb = (eb == 8'd0) && (fb != 23'd0);
        st = {5'd0, denb, dena, nanb, nana};
        l = (cmd == CMD_B_SUB) ? source_b : source_a;
        r = (cmd == CMD_B_SUB) ? source_a : source_b;
        if (cmd != CMD_ADD) begin
            r[31] = ~r[31];
        end
        le = l[30:23];
        re = r[30:23];
        if (le == 8'd0) l[30:0] = 31'd0;
        if (re == 8'd0) r[30:0] = 31'd0;
        ls = l[31];
        rs = r[31];
        ls0 = {1'b1, l[22:0], 3'd0};
        rs0 = {1'b1, r[22:0], 3'd0};
        s1_next = '0;
        s1_next.rm = rm_reg;
        s1_next.sign_l = ls;
        s1_next.sign_r = rs;
        if (nana || nanb) begin
            if ((nana && !(|(fa & QUIET_BIT))) || (nanb && !(|(fb & QUIET_BIT))))
                st[4] = 1'b1;
            s1_next.done = 1'b1;
            s1_next.res  = QNAN_OUT;
        end else begin
            if ((dena && !infb) || (denb && !infa)) st[7] = 1'b1;
            s1_next.done = 1'b1;
            if (le == 8'hff || re == 8'hff) begin
                if (le == 8'hff && re == 8'hff && ls != rs) begin
                    st[4] = 1'b1;
                    s1_next.res = QNAN_OUT;
                end else begin
                    st[5] = 1'b1;
                    s1_next.res = ((le == 8'hff) ? l : r) & INF_MASK;
                end
            end else if (le == 8'd0 && re == 8'd0) begin
                s1_next.res = {(ls == rs) ? ls : (rm_reg == RM_MINUS), 31'd0};
            end else if (le == 8'd0) begin
                s1_next.res = r;
            end else if (re == 8'd0) begin
                s1_next.res = l;
            end else begin
                s1_next.done = 1'b0;
                if (le > re) begin
                    s1_next.lsig = ls0;
                    s1_next.rsig = jam27(rs0, le - re);
                    s1_next.exp  = le;
                end else begin
                    s1_next.lsig = jam27(ls0, re - le);
                    s1_next.rsig = rs0;
                    s1_next.exp  = re;
                end
            end
        end
        s1_next.flags = st;
    end

    // stage 2: add or subtract, normalize
    always_comb begin
        logic [27:0] sum;
        logic [26:0] d;
        logic [4:0]  lz;
        s2_next = '0;
        s2_next.done  = s1_reg.done;
        s2_next.res   = s1_reg.res;
        s2_next.flags = s1_reg.flags;
        s2_next.rm    = s1_reg.rm;
        sum = '0;
        d   = '0;
        lz  = '0;
        if (!s1_reg.done) begin
            if (s1_reg.sign_l == s1_reg.sign_r) begin
                s2_next.sign = s1_reg.sign_l;
                sum = {1'b0, s1_reg.lsig} + {1'b0, s1_reg.rsig};
                if (sum[27]) begin
                    s2_next.sig = {sum[27:2], |sum[1:0]};
                    s2_next.exp = 10'(s1_reg.exp) + 10'sd1;
                end else begin
                    s2_next.sig = sum[26:0];
                    s2_next.exp = 10'(s1_reg.exp);
                end
            end else if (s1_reg.lsig == s1_reg.rsig) begin
                s2_next.done = 1'b1;
                s2_next.res  = {s1_reg.rm == RM_MINUS, 31'd0};
            end else begin
                if (s1_reg.lsig > s1_reg.rsig) begin
                    s2_next.sign = s1_reg.sign_l;
                    d = s1_reg.lsig - s1_reg.rsig;
                end else begin
                    s2_next.sign = s1_reg.sign_r;
                    d = s1_reg.rsig - s1_reg.lsig;
                end
                lz = lzc27(d);
                s2_next.sig = d << lz;
                s2_next.exp = 10'(s1_reg.exp) - 10'(lz);
            end
        end
    end

    // stage 3: round, overflow, underflow, pack
    always_comb begin
        logic [23:0] mant;
        logic [24:0] mi;
        logic [2:0]  rem;
        logic        inc, sgn, dir;
        logic signed [9:0] e;
        logic [1:0]  rm;
        res3_next = s2_reg.res;
        fl3_next  = s2_reg.flags;
        rm   = s2_reg.rm;
        sgn  = s2_reg.sign;
        e    = s2_reg.exp;
        mant = s2_reg.sig[26:3];
        rem  = s2_reg.sig[2:0];
        dir  = (rm == RM_PLUS && !sgn) || (rm == RM_MINUS && sgn);
        inc  = (rm == RM_NEAREST && (rem > 3'd4 || (rem == 3'd4 && mant[0])))
               || (dir && rem != 3'd0);
        mi   = {1'b0, mant} + {24'd0, inc};
        if (mi[24]) begin
            mi = mi >> 1;
            e  = e + 10'sd1;
        end
        if (!s2_reg.done) begin
            if (s2_reg.exp <= 10'sd0) begin
                fl3_next[8] = 1'b1;
                fl3_next[7] = 1'b1;
                res3_next = {sgn, 31'd0} | (dir ? MIN_NORM : 32'd0);
            end else if (e >= 10'sd255) begin
                fl3_next[7] = 1'b1;
                fl3_next[6] = 1'b1;
                if (rm == RM_NEAREST || dir) begin
                    fl3_next[5] = 1'b1;
                    res3_next = {sgn, 31'd0} | INF_PAT;
                end else begin
                    res3_next = {sgn, 31'd0} | MAX_FIN;
                end
            end else begin
                if (rem != 3'd0) fl3_next[7] = 1'b1;
                res3_next = {sgn, e[7:0], mi[22:0]};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        res3_reg <= res3_next;
        fl3_reg  <= fl3_next;
    end

    assign done           = v3_reg;
    assign sum_value      = res3_reg;
    assign a_is_nan       = fl3_reg[0];
    assign b_is_nan       = fl3_reg[1];
    assign a_is_denormal  = fl3_reg[2];
    assign b_is_denormal  = fl3_reg[3];
    assign invalid_flag   = fl3_reg[4];
    assign infinite_flag  = fl3_reg[5];
    assign overflow_flag  = fl3_reg[6];
    assign inexact_flag   = fl3_reg[7];
    assign underflow_flag = fl3_reg[8];
endmodule
`default_nettype wire

// ===== src/fpadd_checker.sv =====
// Checker: port-level properties of the binary32 add/subtract block.
`default_nettype none
module fpadd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] sum_value,
    input wire logic        a_is_nan,
    input wire logic        b_is_nan,
    input wire logic        infinite_flag,
    input wire logic        overflow_flag,
    input wire logic        inexact_flag,
    input wire logic        underflow_flag
);
    // every accepted beat is followed by a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done) else $error("missing result");

    // no result without an earlier accepted beat
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3)) else $error("spurious result");

    // NaN input gives the fixed pattern
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (a_is_nan || b_is_nan)) |-> (sum_value == 32'h7fffffff))
        else $error("nan result");

    // overflow and underflow always flag inexact
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (overflow_flag || underflow_flag)) |-> inexact_flag)
        else $error("inexact missing");

    // infinite flag matches an infinite pattern
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && infinite_flag) |-> (sum_value[30:0] == 31'h7f800000))
        else $error("infinite mismatch");
endmodule

bind binary32_add_subtract_top fpadd_checker u_fpadd_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .sum_value(sum_value), .a_is_nan(a_is_nan), .b_is_nan(b_is_nan),
    .infinite_flag(infinite_flag), .overflow_flag(overflow_flag),
    .inexact_flag(inexact_flag), .underflow_flag(underflow_flag)
);
`default_nettype wire
